@@ rtl/ece_pkg.sv @@
package ece_pkg;

  // Fixed-point format: FRAC_BITS fractional bits, ONE stands for 1.0
  localparam int FRAC_BITS  = 16;
  localparam int SINE_DEPTH = 256;

  localparam int VAL_W   = FRAC_BITS + 1;
  localparam int RES_W   = VAL_W + 2;
  localparam int SQ_W    = 2 * VAL_W;
  localparam int IDX_W   = $clog2(SINE_DEPTH);
  localparam int POS_W   = VAL_W + IDX_W;
  localparam int SH_W    = $clog2(FRAC_BITS + 2);
  localparam int OP_W    = 4;
  localparam int TDATA_W = ((VAL_W + 7) / 8) * 8;

  localparam logic [VAL_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [VAL_W-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [OP_W-1:0] {
    OP_IN_SINE     = 4'd0,
    OP_IN_QUAD     = 4'd1,
    OP_IN_CUBIC    = 4'd2,
    OP_OUT_SINE    = 4'd3,
    OP_OUT_QUAD    = 4'd4,
    OP_OUT_CUBIC   = 4'd5,
    OP_INOUT_SINE  = 4'd6,
    OP_INOUT_QUAD  = 4'd7,
    OP_INOUT_CUBIC = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    K_QUAD,
    K_CUBE,
    K_SINE,
    K_PASS
  } kind_t;

  // How the interpolated sine turns into the curve value
  typedef enum logic [1:0] {
    SF_DIRECT,
    SF_COMPL,
    SF_LOWER_HALF,
    SF_UPPER_HALF
  } sform_t;

  typedef struct packed {
    kind_t            kind;
    logic [SH_W-1:0]  sq_sh;
    logic [SH_W-1:0]  cu_sh;
    logic             sub_one;
    sform_t           sform;
  } ctl_t;

  // Divide a Taylor term by (2n)(2n+1)
  function automatic logic [63:0] taylor_div(input logic [63:0] term, input int n);
    logic [63:0] q;
    unique case (n)
      1:       q = term / 64'd6;
      2:       q = term / 64'd20;
      3:       q = term / 64'd42;
      4:       q = term / 64'd72;
      5:       q = term / 64'd110;
      6:       q = term / 64'd156;
      default: q = term / 64'd210;
    endcase
    return q;
  endfunction

  // Quarter-wave sine entry k: sin(k*pi/(2*SINE_DEPTH)), Taylor series to x^15 in Q30
  function automatic logic [VAL_W-1:0] sine_entry(input int k);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
    term = x;
    sum  = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = taylor_div(term, n);
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (v > 64'(ONE)) begin
      v = 64'(ONE);
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/ece_sine_rom.sv @@
module ece_sine_rom (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ece_pkg::IDX_W-1:0]  idx,
  output logic [ece_pkg::VAL_W-1:0]  lo_q,
  output logic [ece_pkg::VAL_W-1:0]  hi_q
);

  // lo_tab holds entries 0..DEPTH-1, hi_tab entries 1..DEPTH
  logic [ece_pkg::VAL_W-1:0] lo_tab [ece_pkg::SINE_DEPTH];
  logic [ece_pkg::VAL_W-1:0] hi_tab [ece_pkg::SINE_DEPTH];

  for (genvar k = 0; k < ece_pkg::SINE_DEPTH; k++) begin : g_tab
    localparam logic [ece_pkg::VAL_W-1:0] LoVal = ece_pkg::sine_entry(k);
    localparam logic [ece_pkg::VAL_W-1:0] HiVal = ece_pkg::sine_entry(k + 1);
    assign lo_tab[k] = LoVal;
    assign hi_tab[k] = HiVal;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_q <= lo_tab[idx];
      hi_q <= hi_tab[idx];
    end
  end

endmodule

@@ rtl/easing_curve_evaluator.sv @@
// Easing curve evaluator: sine, quadratic and cubic easing (in, out, in-out).
//
// Input channel (in_*): one transaction carries a progress value t in
// in_tdata (unsigned, 16 fractional bits, 0x10000 = 1.0; larger values are
// clamped to 1.0) and a curve selector in in_tuser. Unknown selectors return
// the clamped t unchanged.
// Output channel (out_*): one transaction per input transaction, in order,
// carrying the eased value in the same format.
//
// An accepted input passes through the registers of each stage in order, and
// out_tvalid rises once it reaches the output register. Throughput: one
// transaction per cycle while out_tready stays high, set by the five-stage
// pipeline (operand prep, square / sine ROM read, round and interpolate
// multiply, cube multiply, final combine) with at most one multiplier per
// path per stage.
//
// Reset (synchronous, active low) clears every stage valid bit; in_tready
// is high in the first cycle after reset. When the receiver holds
// out_tready low, the output register holds its transaction and each stage
// behind it advances only into an empty slot, so bubbles are squeezed out
// before in_tready drops.
module easing_curve_evaluator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ece_pkg::TDATA_W-1:0]   in_tdata,   // [16:0] progress, rest zero
  input  logic [ece_pkg::OP_W-1:0]      in_tuser,   // [3:0] operation
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ece_pkg::TDATA_W-1:0]   out_tdata   // [16:0] eased_value, rest zero
);

  localparam int F     = ece_pkg::FRAC_BITS;
  localparam int VAL_W = ece_pkg::VAL_W;
  localparam int RES_W = ece_pkg::RES_W;
  localparam int SQ_W  = ece_pkg::SQ_W;
  localparam int POS_W = ece_pkg::POS_W;
  localparam int IDX_W = ece_pkg::IDX_W;
  localparam int SH_W  = ece_pkg::SH_W;
  localparam int CUB_W = VAL_W + VAL_W;
  localparam int D_W   = VAL_W + F;

  // 1.0 minus x, floored at zero
  function automatic logic [RES_W-1:0] sub_from_one(input logic [RES_W-1:0] x);
    return (x >= RES_W'(ece_pkg::ONE)) ? '0 : RES_W'(ece_pkg::ONE) - x;
  endfunction

  // Stage enables: a stage advances when it is empty or the next one advances
  logic en1, en2, en3, en4, en5;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign en5       = !v5_r || out_tready;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: clamp t, pick the polynomial operand and the sine argument
  // ---------------------------------------------------------------------
  logic [VAL_W-1:0] t_in, t_sat, u0, v0, a0, p0, lo_arg0, hi_arg0;
  logic [VAL_W:0]   t2_0, v_wide0, lo_wide0, hi_wide0;
  logic             below_half0, upto_half0;
  ece_pkg::ctl_t    ctl0;

  always_comb begin
    t_in        = in_tdata[VAL_W-1:0];
    t_sat       = (t_in > ece_pkg::ONE) ? ece_pkg::ONE : t_in;
    u0          = ece_pkg::ONE - t_sat;
    t2_0        = {t_sat, 1'b0};
    v_wide0     = {ece_pkg::ONE, 1'b0} - t2_0;
    lo_wide0    = {1'b0, ece_pkg::ONE} - t2_0;
    hi_wide0    = t2_0 - {1'b0, ece_pkg::ONE};
    v0          = v_wide0[VAL_W-1:0];
    lo_arg0     = lo_wide0[VAL_W-1:0];
    hi_arg0     = hi_wide0[VAL_W-1:0];
    below_half0 = t_sat < ece_pkg::HALF;
    upto_half0  = t_sat <= ece_pkg::HALF;

    a0            = t_sat;
    p0            = t_sat;
    ctl0.kind     = ece_pkg::K_PASS;
    ctl0.sq_sh    = SH_W'(F);
    ctl0.cu_sh    = SH_W'(F);
    ctl0.sub_one  = 1'b0;
    ctl0.sform    = ece_pkg::SF_DIRECT;

    unique case (ece_pkg::op_t'(in_tuser))
      ece_pkg::OP_IN_SINE: begin
        ctl0.kind  = ece_pkg::K_SINE;
        ctl0.sform = ece_pkg::SF_COMPL;
        p0         = u0;
      end
      ece_pkg::OP_IN_QUAD: begin
        ctl0.kind = ece_pkg::K_QUAD;
      end
      ece_pkg::OP_IN_CUBIC: begin
        ctl0.kind = ece_pkg::K_CUBE;
      end
      ece_pkg::OP_OUT_SINE: begin
        ctl0.kind = ece_pkg::K_SINE;
      end
      ece_pkg::OP_OUT_QUAD: begin
        ctl0.kind    = ece_pkg::K_QUAD;
        ctl0.sub_one = 1'b1;
        a0           = u0;
      end
      ece_pkg::OP_OUT_CUBIC: begin
        ctl0.kind    = ece_pkg::K_CUBE;
        ctl0.sub_one = 1'b1;
        a0           = u0;
      end
      ece_pkg::OP_INOUT_SINE: begin
        ctl0.kind = ece_pkg::K_SINE;
        if (upto_half0) begin
          ctl0.sform = ece_pkg::SF_LOWER_HALF;
          p0         = lo_arg0;
        end else begin
          ctl0.sform = ece_pkg::SF_UPPER_HALF;
          p0         = hi_arg0;
        end
      end
      ece_pkg::OP_INOUT_QUAD: begin
        ctl0.kind = ece_pkg::K_QUAD;
        if (below_half0) begin
          ctl0.sq_sh = SH_W'(F - 1);
        end else begin
          ctl0.sq_sh   = SH_W'(F + 1);
          ctl0.sub_one = 1'b1;
          a0           = v0;
        end
      end
      ece_pkg::OP_INOUT_CUBIC: begin
        ctl0.kind = ece_pkg::K_CUBE;
        if (below_half0) begin
          // factor of four folded into the final rounding shift
          ctl0.cu_sh = SH_W'(F - 2);
        end else begin
          ctl0.cu_sh   = SH_W'(F + 1);
          ctl0.sub_one = 1'b1;
          a0           = v0;
        end
      end
      default: begin
        ctl0.kind = ece_pkg::K_PASS;
      end
    endcase
  end

  ece_pkg::ctl_t    ctl1_r;
  logic [VAL_W-1:0] t1_r, a1_r, p1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1_r <= ctl0;
      t1_r   <= t_sat;
      a1_r   <= a0;
      p1_r   <= p0;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: square the operand, address the sine ROM
  // ---------------------------------------------------------------------
  logic [SQ_W-1:0]  sq2_nxt;
  logic [POS_W-1:0] pos1;
  logic [IDX_W:0]   seg1;
  logic             end1;
  logic [F-1:0]     frac1;
  logic [IDX_W-1:0] idx1;

  always_comb begin
    sq2_nxt = SQ_W'(a1_r) * SQ_W'(a1_r);
    pos1    = POS_W'(p1_r) * POS_W'(ece_pkg::SINE_DEPTH);
    seg1    = pos1[POS_W-1:F];
    end1    = seg1 >= (IDX_W + 1)'(ece_pkg::SINE_DEPTH);
    frac1   = pos1[F-1:0];
    // past the last segment, read the top segment so hi_q is sin(pi/2)
    idx1    = end1 ? {IDX_W{1'b1}} : seg1[IDX_W-1:0];
  end

  logic [VAL_W-1:0] rom_lo, rom_hi;

  ece_sine_rom u_sine_rom (
    .clk  (clk),
    .en   (en2),
    .idx  (idx1),
    .lo_q (rom_lo),
    .hi_q (rom_hi)
  );

  ece_pkg::ctl_t    ctl2_r;
  logic [VAL_W-1:0] t2_r, a2_r;
  logic [SQ_W-1:0]  sq2_r;
  logic [F-1:0]     frac2_r;
  logic             end2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      ctl2_r  <= ctl1_r;
      t2_r    <= t1_r;
      a2_r    <= a1_r;
      sq2_r   <= sq2_nxt;
      frac2_r <= frac1;
      end2_r  <= end1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: round the square, multiply the sine slope by the fraction
  // ---------------------------------------------------------------------
  logic [SQ_W-1:0]  sq_rnd2;
  logic [VAL_W-1:0] s3_nxt, diff2;
  logic             neg2;
  logic [D_W-1:0]   d3_nxt;

  always_comb begin
    sq_rnd2 = (sq2_r + (SQ_W'(1) << (ctl2_r.sq_sh - SH_W'(1)))) >> ctl2_r.sq_sh;
    s3_nxt  = sq_rnd2[VAL_W-1:0];
    neg2    = rom_hi < rom_lo;
    diff2   = neg2 ? rom_lo - rom_hi : rom_hi - rom_lo;
    d3_nxt  = D_W'(diff2) * D_W'(frac2_r);
  end

  ece_pkg::ctl_t    ctl3_r;
  logic [VAL_W-1:0] t3_r, a3_r, s3_r, lo3_r, hi3_r;
  logic [D_W-1:0]   d3_r;
  logic             neg3_r, end3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      ctl3_r <= ctl2_r;
      t3_r   <= t2_r;
      a3_r   <= a2_r;
      s3_r   <= s3_nxt;
      d3_r   <= d3_nxt;
      neg3_r <= neg2;
      lo3_r  <= rom_lo;
      hi3_r  <= rom_hi;
      end3_r <= end2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: cube product, finish the sine interpolation
  // ---------------------------------------------------------------------
  logic [CUB_W-1:0] cube4_nxt;
  logic [D_W-1:0]   corr_wide3;
  logic [VAL_W-1:0] corr3, sv4_nxt;

  always_comb begin
    cube4_nxt  = CUB_W'(s3_r) * CUB_W'(a3_r);
    corr_wide3 = (d3_r + (D_W'(1) << (F - 1))) >> F;
    corr3      = corr_wide3[VAL_W-1:0];
    if (end3_r) begin
      // t maps onto the last ROM entry
      sv4_nxt = hi3_r;
    end else if (neg3_r) begin
      sv4_nxt = lo3_r - corr3;
    end else begin
      sv4_nxt = lo3_r + corr3;
    end
  end

  ece_pkg::ctl_t    ctl4_r;
  logic [VAL_W-1:0] t4_r, s4_r, sv4_r;
  logic [CUB_W-1:0] cube4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      ctl4_r  <= ctl3_r;
      t4_r    <= t3_r;
      s4_r    <= s3_r;
      sv4_r   <= sv4_nxt;
      cube4_r <= cube4_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: pick the curve result, mirror it, clamp to 1.0
  // ---------------------------------------------------------------------
  logic [CUB_W-1:0] cube_rnd4;
  logic [RES_W-1:0] sv_ext4, res4, fin4;

  always_comb begin
    cube_rnd4 = (cube4_r + (CUB_W'(1) << (ctl4_r.cu_sh - SH_W'(1)))) >> ctl4_r.cu_sh;
    sv_ext4   = RES_W'(sv4_r);

    unique case (ctl4_r.kind)
      ece_pkg::K_QUAD: res4 = RES_W'(s4_r);
      ece_pkg::K_CUBE: res4 = cube_rnd4[RES_W-1:0];
      ece_pkg::K_SINE: begin
        unique case (ctl4_r.sform)
          ece_pkg::SF_DIRECT:     res4 = sv_ext4;
          ece_pkg::SF_COMPL:      res4 = sub_from_one(sv_ext4);
          ece_pkg::SF_LOWER_HALF: res4 = (sub_from_one(sv_ext4) + RES_W'(1)) >> 1;
          ece_pkg::SF_UPPER_HALF:
            res4 = (RES_W'(ece_pkg::ONE) + sv_ext4 + RES_W'(1)) >> 1;
          default:                res4 = sv_ext4;
        endcase
      end
      ece_pkg::K_PASS: res4 = RES_W'(t4_r);
      default:         res4 = RES_W'(t4_r);
    endcase

    fin4 = ctl4_r.sub_one ? sub_from_one(res4) : res4;
    if (fin4 > RES_W'(ece_pkg::ONE)) begin
      fin4 = RES_W'(ece_pkg::ONE);
    end
  end

  logic [ece_pkg::TDATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      out_tdata_r <= ece_pkg::TDATA_W'(fin4[VAL_W-1:0]);
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ rtl/ece_port_checker.sv @@
module ece_port_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ece_pkg::TDATA_W-1:0]   out_tdata
);

  localparam int VAL_W   = ece_pkg::VAL_W;
  localparam int TDATA_W = ece_pkg::TDATA_W;

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("in_tready low right after reset");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  // Results never exceed 1.0 and padding stays zero
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[VAL_W-1:0] <= ece_pkg::ONE) &&
                   (out_tdata[TDATA_W-1:VAL_W] == '0))
    else $error("eased value out of range");

  // An accepted transaction reaches the output while the output side stays open
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      ##1 out_tready |=> out_tvalid)
    else $error("accepted transaction did not emerge after five cycles");

endmodule

bind easing_curve_evaluator ece_port_checker u_port_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ece_pkg::*;

  // Stimulus sizes and run limits
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_AT      = 1000;  // inputs taken before the long output hold-off
  localparam int HOLD_LEN     = 150;   // cycles the receiver refuses results
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transaction before giving up
  localparam int DRAIN_CYCLES = 20;    // pipeline is five deep, leave generous slack

  localparam logic [OP_W-1:0] FIRST_UNKNOWN = OP_W'(OP_INOUT_CUBIC + 1);
  localparam logic [OP_W-1:0] LAST_CODE     = '1;

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;  // pi/2 in Q30
  localparam longint unsigned FULL   = 64'(ONE);
  localparam longint unsigned HALF_L = 64'(HALF);

  // One accepted input and the value it must produce
  typedef struct {
    logic [OP_W-1:0]  code;
    logic [VAL_W-1:0] progress;
    logic [VAL_W-1:0] eased;
  } eased_request_t;

  // Predicts each eased value and keeps them in arrival order
  class eased_value_tracker;
    eased_request_t  pending_eased[$];
    longint unsigned sine_quarter[SINE_DEPTH + 1];
    int mismatches       = 0;
    int results_checked  = 0;
    int inputs_noted     = 0;
    int saturated_inputs = 0;
    int unknown_codes    = 0;

    // Build the quarter-wave sine table from its Taylor series in Q30
    function new();
      longint unsigned x, term, sum, v;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
        x    = (QUARTER_TURN_Q30 * 64'(k)) / 64'(SINE_DEPTH);
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
          term = (((term * x) >> 30) * x) >> 30;
          term = term / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
          end else begin
            sum = sum + term;
          end
        end
        v = round_shift(sum, 30 - FRAC_BITS);
        sine_quarter[k] = (v > FULL) ? FULL : v;
      end
    endfunction

    // Round half up while dropping s bits
    function longint unsigned round_shift(longint unsigned x, int s);
      return (x + (64'd1 << (s - 1))) >> s;
    endfunction

    function longint unsigned squared(longint unsigned a);
      return round_shift(a * a, FRAC_BITS);
    endfunction

    function longint unsigned one_minus(longint unsigned x);
      return (x >= FULL) ? 64'd0 : FULL - x;
    endfunction

    // sin(p * pi / (2 * ONE)) with linear interpolation between table entries
    function longint unsigned sine_lookup(longint unsigned p);
      longint unsigned pos, idx, frac, a, b;
      if (p > FULL) p = FULL;
      pos  = p * SINE_DEPTH;
      idx  = pos >> FRAC_BITS;
      frac = pos & (FULL - 1);
      if (idx >= SINE_DEPTH) return sine_quarter[SINE_DEPTH];
      a = sine_quarter[int'(idx)];
      b = sine_quarter[int'(idx) + 1];
      if (b >= a) return a + round_shift((b - a) * frac, FRAC_BITS);
      return a - round_shift((a - b) * frac, FRAC_BITS);
    endfunction

    function logic [VAL_W-1:0] predict_eased(logic [OP_W-1:0] code, logic [VAL_W-1:0] raw);
      longint unsigned t, u, v, r;
      t = (64'(raw) > FULL) ? FULL : 64'(raw);
      u = FULL - t;
      v = 2 * FULL - 2 * t;
      case (code)
        OP_IN_SINE:   r = one_minus(sine_lookup(FULL - t));
        OP_IN_QUAD:   r = squared(t);
        OP_IN_CUBIC:  r = round_shift(squared(t) * t, FRAC_BITS);
        OP_OUT_SINE:  r = sine_lookup(t);
        OP_OUT_QUAD:  r = one_minus(squared(u));
        OP_OUT_CUBIC: r = one_minus(round_shift(squared(u) * u, FRAC_BITS));
        OP_INOUT_SINE: begin
          if (t <= HALF_L) r = round_shift(one_minus(sine_lookup(FULL - 2 * t)), 1);
          else             r = round_shift(FULL + sine_lookup(2 * t - FULL), 1);
        end
        OP_INOUT_QUAD: begin
          if (t < HALF_L) r = round_shift(t * t, FRAC_BITS - 1);
          else            r = one_minus(round_shift(v * v, FRAC_BITS + 1));
        end
        OP_INOUT_CUBIC: begin
          if (t < HALF_L) r = round_shift(4 * squared(t) * t, FRAC_BITS);
          else            r = one_minus(round_shift(squared(v) * v, FRAC_BITS + 1));
        end
        default: r = t;
      endcase
      if (r > FULL) r = FULL;
      return r[VAL_W-1:0];
    endfunction

    function void note_input(logic [OP_W-1:0] code, logic [VAL_W-1:0] raw);
      eased_request_t req;
      req.code     = code;
      req.progress = raw;
      req.eased    = predict_eased(code, raw);
      pending_eased.push_back(req);
      inputs_noted++;
      if (64'(raw) > FULL) saturated_inputs++;
      if (code > OP_INOUT_CUBIC) unknown_codes++;
    endfunction

    function void check_result(logic [TDATA_W-1:0] word);
      eased_request_t req;
      results_checked++;
      if (pending_eased.size() == 0) begin
        mismatches++;
        $display("%0t: eased_value %0d arrived with no transaction pending",
                 $time, word[VAL_W-1:0]);
        return;
      end
      req = pending_eased.pop_front();
      if (word[VAL_W-1:0] !== req.eased) begin
        mismatches++;
        $display("%0t: eased_value differs (op %0d, progress 0x%05h): expected %0d, got %0d",
                 $time, req.code, req.progress, req.eased, word[VAL_W-1:0]);
      end
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;   // [16:0] progress, rest zero
  logic [OP_W-1:0]    in_tuser   = '0;   // [3:0] operation
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;         // [16:0] eased_value, rest zero

  eased_value_tracker tracker;

  // Receiver behavior; changed only by nonblocking assignment so every
  // process sees the same value at a given edge
  int rx_stall_pct = 55;
  int inputs_taken = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int quiet_cycles = 0;

  easing_curve_evaluator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Input monitor: note each accepted transaction at the edge that takes it
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      tracker.note_input(in_tuser, in_tdata[VAL_W-1:0]);
      inputs_taken <= inputs_taken + 1;
    end
  end

  // Output monitor: compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata);
    end
  end

  // Receiver: random stalls, plus one long hold-off once enough inputs went in.
  // The sender keeps offering during the hold so the pipeline fills and
  // in_tready has to drop.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!hold_done && inputs_taken >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_LEN - 1;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: stop the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, tracker.pending_eased.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one transaction, optionally after a short idle gap, and hold it
  // until the edge at which the block takes it. Leave in_tvalid high on
  // return so back-to-back items need no extra assignment.
  task automatic send_transaction(input logic [OP_W-1:0] code, input logic [VAL_W-1:0] t,
                                  input int idle_pct);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? int'($urandom_range(3, 1)) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= code;
    in_tdata  <= TDATA_W'(t);
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int               tx_idle_pct;
    int               pick;
    logic [OP_W-1:0]  code;
    logic [VAL_W-1:0] t;

    tracker     = new();
    tx_idle_pct = 16;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ends of the range for every curve
    for (int c = OP_IN_SINE; c <= OP_INOUT_CUBIC; c++) begin
      send_transaction(OP_W'(c), '0, tx_idle_pct);
      send_transaction(OP_W'(c), ONE, tx_idle_pct);
    end
    // Both sides of the in-out split
    for (int c = OP_INOUT_SINE; c <= OP_INOUT_CUBIC; c++) begin
      send_transaction(OP_W'(c), HALF - 1'b1, tx_idle_pct);
      send_transaction(OP_W'(c), HALF, tx_idle_pct);
    end
    // Saturation of progress above one, and unknown selectors passing t through
    send_transaction(OP_OUT_SINE, '1, tx_idle_pct);
    send_transaction(FIRST_UNKNOWN, '1, tx_idle_pct);
    send_transaction(LAST_CODE, 17'h0ABCD, tx_idle_pct);

    // Random: three phases of idle/stall mix, the last one without idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 55;
        rx_stall_pct <= 16;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
      end

      if ($urandom_range(99) < 85) code = OP_W'($urandom_range(OP_INOUT_CUBIC, OP_IN_SINE));
      else                         code = OP_W'($urandom_range(LAST_CODE, FIRST_UNKNOWN));

      pick = int'($urandom_range(99));
      if (pick < 55)      t = VAL_W'($urandom_range(ONE, 0));
      else if (pick < 70) t = VAL_W'($urandom_range(HALF + 3, HALF - 3));
      else if (pick < 75) t = VAL_W'($urandom_range(7, 0));
      else if (pick < 80) t = VAL_W'($urandom_range(ONE, ONE - 7));
      else                t = VAL_W'($urandom_range((1 << VAL_W) - 1, 0));

      send_transaction(code, t, tx_idle_pct);
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every predicted result, then let the pipeline settle
    while (tracker.pending_eased.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions on nine curves: %0d unknown, %0d above one; %0d checked.",
             tracker.inputs_noted, tracker.unknown_codes, tracker.saturated_inputs,
             tracker.results_checked);
    $display("Idle mixes 16/55, 55/16 and none, plus a %0d-cycle output hold-off.",
             HOLD_LEN);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
